// ===== rtl/core/sync_disciplined_timestamp_tagger_assert.svh =====
`ifndef SYNC_DISCIPLINED_TIMESTAMP_TAGGER_ASSERT_SVH
`define SYNC_DISCIPLINED_TIMESTAMP_TAGGER_ASSERT_SVH

// clocked assertion with asynchronous active-low reset
`define SDTT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sdtt assertion failed");

`endif

// ===== rtl/core/sdtt_pkg.sv =====
`default_nettype none
package sdtt_pkg;

    localparam int CHANNEL_COUNT    = 14;
    localparam int GOOD_SYNC_PULSES = 4;
    localparam int COUNTER_BITS     = 16;

    localparam logic [62:0] COUNTER_SPAN = 63'(64'd1 << COUNTER_BITS);

    localparam logic [2:0] CMD_CAPTURE    = 3'd0;
    localparam logic [2:0] CMD_OVF_START  = 3'd1;
    localparam logic [2:0] CMD_OVF_COMMIT = 3'd2;
    localparam logic [2:0] CMD_SET_NOW    = 3'd3;
    localparam logic [2:0] CMD_ARM        = 3'd4;

    localparam logic [1:0] LOCK_LOW     = 2'd0;
    localparam logic [1:0] LOCK_HIGH    = 2'd1;
    localparam logic [1:0] LOCK_UNKNOWN = 2'd2;

    localparam logic [1:0] REG_SYNC_CHANNEL = 2'd0;
    localparam logic [1:0] REG_IDEAL_HIGH   = 2'd1;
    localparam logic [1:0] REG_IDEAL_LOW    = 2'd2;
    localparam logic [1:0] REG_CH_ENABLE    = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  channel_index;
        logic [15:0] capture_value;
        logic [15:0] counter_now;
        logic        pin_level;
        logic        in_overflow;
        logic [62:0] time_value;
    } in_item_t;

    typedef struct packed {
        logic [62:0] timestamp;
        logic        edge_level;
        logic [3:0]  source_channel;
        logic        synchronized;
    } out_item_t;

    typedef struct packed {
        logic [3:0]  sync_channel;
        logic [31:0] ideal_high_period;
        logic [31:0] ideal_low_period;
        logic [13:0] channel_enable;
    } cfg_t;

    // one capture handed from the front to the back
    typedef struct packed {
        logic [62:0] t;
        logic        level;
        logic [3:0]  ch;
        logic [1:0]  lock;
        logic [31:0] ideal;
        logic [62:0] meas;
        logic [62:0] last_meas;
        logic [62:0] last_ideal;
    } job_t;

endpackage
`default_nettype wire

// ===== rtl/core/sdtt_front.sv =====
`default_nettype none
module sdtt_front
    import sdtt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t in_item,
    output logic          job_valid,
    output job_t          job,
    input  wire logic     job_pop
);

    logic [62:0] coarse_reg, coarse_next;
    logic [62:0] pend_reg, pend_next;
    logic [62:0] lms_reg, lms_next;
    logic [62:0] lis_reg, lis_next;
    logic [62:0] mhigh_reg, mhigh_next;
    logic [62:0] mlow_reg, mlow_next;
    logic [1:0]  lock_reg, lock_next;
    logic [7:0]  pcnt_reg, pcnt_next;
    logic [62:0] req_reg, req_next;
    logic        armed_reg, armed_next;

    job_t        q_mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;

    logic        accept, cap_ok, is_sync, loaded;
    logic [62:0] t, diff;
    job_t        new_job;

    assign accept = push && !full;
    assign full   = (count_reg == 2'd2);

    always_comb
    begin
        coarse_next = coarse_reg;
        pend_next   = pend_reg;
        lms_next    = lms_reg;
        lis_next    = lis_reg;
        mhigh_next  = mhigh_reg;
        mlow_next   = mlow_reg;
        lock_next   = lock_reg;
        pcnt_next   = pcnt_reg;
        req_next    = req_reg;
        armed_next  = armed_reg;
        loaded      = 1'b0;
        cap_ok      = (in_item.cmd == CMD_CAPTURE)
                   && (in_item.channel_index < 4'(CHANNEL_COUNT))
                   && cfg.channel_enable[in_item.channel_index];
        is_sync     = (cfg.sync_channel < 4'(CHANNEL_COUNT))
                   && (cfg.sync_channel == in_item.channel_index);
        t = (in_item.in_overflow && in_item.capture_value < in_item.counter_now)
          ? pend_reg + 63'(in_item.capture_value)
          : coarse_reg + 63'(in_item.capture_value);
        diff = t - lms_reg;
        unique case (in_item.cmd)
            CMD_OVF_START:  pend_next = coarse_reg + COUNTER_SPAN;
            CMD_OVF_COMMIT: coarse_next = pend_reg;
            CMD_SET_NOW:
            begin
                coarse_next = in_item.time_value - 63'(in_item.counter_now);
                pend_next   = coarse_next + COUNTER_SPAN;
            end
            CMD_ARM:
            begin
                req_next   = in_item.time_value;
                armed_next = 1'b1;
            end
            CMD_CAPTURE:
            begin
                if (cap_ok && is_sync)
                begin
                    if (in_item.pin_level)
                    begin
                        mlow_next = diff;
                        if (armed_reg)
                        begin
                            coarse_next = req_reg - 63'(in_item.counter_now);
                            if (in_item.in_overflow)
                                pend_next = coarse_next + COUNTER_SPAN;
                            lis_next   = req_reg;
                            armed_next = 1'b0;
                            lock_next  = LOCK_UNKNOWN;
                            pcnt_next  = 8'd0;
                            loaded     = 1'b1;
                        end
                        else
                            lis_next = lis_reg + 63'(cfg.ideal_low_period);
                    end
                    else
                    begin
                        mhigh_next = diff;
                        lis_next   = lis_reg + 63'(cfg.ideal_high_period);
                    end
                    lms_next = t;
                    if (!loaded)
                    begin
                        if (pcnt_reg >= 8'(GOOD_SYNC_PULSES))
                            lock_next = in_item.pin_level ? LOCK_HIGH : LOCK_LOW;
                        else
                            pcnt_next = pcnt_reg + 8'd1;
                    end
                end
            end
            default: ;
        endcase
        new_job.t          = t;
        new_job.level      = in_item.pin_level;
        new_job.ch         = in_item.channel_index;
        new_job.lock       = lock_next;
        new_job.ideal      = (lock_next == LOCK_HIGH) ? cfg.ideal_high_period
                                                      : cfg.ideal_low_period;
        new_job.meas       = (lock_next == LOCK_HIGH) ? mhigh_next : mlow_next;
        new_job.last_meas  = lms_next;
        new_job.last_ideal = lis_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coarse_reg <= '0;
            pend_reg   <= '0;
            lms_reg    <= '0;
            lis_reg    <= '0;
            mhigh_reg  <= '0;
            mlow_reg   <= '0;
            lock_reg   <= LOCK_UNKNOWN;
            pcnt_reg   <= '0;
            req_reg    <= '0;
            armed_reg  <= 1'b0;
        end
        else if (accept)
        begin
            coarse_reg <= coarse_next;
            pend_reg   <= pend_next;
            lms_reg    <= lms_next;
            lis_reg    <= lis_next;
            mhigh_reg  <= mhigh_next;
            mlow_reg   <= mlow_next;
            lock_reg   <= lock_next;
            pcnt_reg   <= pcnt_next;
            req_reg    <= req_next;
            armed_reg  <= armed_next;
        end
    end

    // two-entry job queue toward the back
    logic do_wr, do_rd;
    assign do_wr     = accept && cap_ok;
    assign do_rd     = job_pop && job_valid;
    assign job_valid = (count_reg != 2'd0);
    assign job       = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            q_mem_reg[wr_ptr_reg] <= new_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 2'd1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sdtt_back.sv =====
`default_nettype none
module sdtt_back
    import sdtt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  job_valid,
    input  wire job_t  job,
    output logic       job_pop,
    output logic       empty,
    input  wire logic  pop,
    output out_item_t  out_item
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_PREP = 3'd1;
    localparam logic [2:0] B_MUL0 = 3'd2;
    localparam logic [2:0] B_MUL1 = 3'd3;
    localparam logic [2:0] B_DIV  = 3'd4;
    localparam logic [2:0] B_FIN  = 3'd5;
    localparam logic [2:0] B_DONE = 3'd6;

    logic [2:0]  state_reg;
    job_t        job_reg;
    logic [62:0] dist_reg;
    logic        after_reg;
    logic [95:0] prod_reg;
    logic [62:0] rem_reg;
    logic [62:0] quo_reg;
    logic        sat_reg;
    logic [6:0]  cnt_reg;
    logic [62:0] tout_reg;
    out_item_t   res_reg;
    logic        res_valid_reg;

    logic        after;
    logic [62:0] delta, off;
    logic [63:0] rsh;
    logic        ge;

    assign job_pop  = (state_reg == B_IDLE) && job_valid;
    assign empty    = !res_valid_reg;
    assign out_item = res_reg;

    always_comb
    begin
        after = job_reg.t >= job_reg.last_meas;
        delta = after ? job_reg.t - job_reg.last_meas : job_reg.last_meas - job_reg.t;
        rsh   = {rem_reg, prod_reg[95]};
        ge    = rsh >= {1'b0, job_reg.meas};
        off   = sat_reg ? '1 : quo_reg;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
                if (job_valid)
                    job_reg <= job;
            B_PREP:
            begin
                after_reg <= after;
                dist_reg  <= delta;
                if (job_reg.lock == LOCK_UNKNOWN)
                    tout_reg <= job_reg.t;
                else
                    tout_reg <= job_reg.last_ideal;
            end
            B_MUL0:
                prod_reg <= {32'd0, 64'(job_reg.ideal * dist_reg[31:0])};
            B_MUL1:
            begin
                prod_reg <= prod_reg + {1'b0, 63'(job_reg.ideal * dist_reg[62:32]), 32'd0};
                rem_reg  <= '0;
                quo_reg  <= '0;
                sat_reg  <= 1'b0;
                cnt_reg  <= 7'd95;
            end
            B_DIV:
            begin
                // one quotient bit a cycle, top bits only flag saturation
                rem_reg  <= ge ? 63'(rsh - {1'b0, job_reg.meas}) : rsh[62:0];
                prod_reg <= {prod_reg[94:0], 1'b0};
                if (cnt_reg >= 7'd63)
                    sat_reg <= sat_reg | ge;
                else
                    quo_reg <= {quo_reg[61:0], ge};
                cnt_reg <= cnt_reg - 7'd1;
            end
            B_FIN:
                tout_reg <= after_reg ? job_reg.last_ideal + off
                                      : job_reg.last_ideal - off;
            B_DONE:
                if (!res_valid_reg || pop)
                begin
                    res_reg.timestamp      <= tout_reg;
                    res_reg.edge_level     <= job_reg.level;
                    res_reg.source_channel <= job_reg.ch;
                    res_reg.synchronized   <= (job_reg.lock != LOCK_UNKNOWN);
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && res_valid_reg)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                    if (job_valid)
                        state_reg <= B_PREP;
                B_PREP:
                    if (job_reg.lock == LOCK_UNKNOWN || job_reg.meas == '0)
                        state_reg <= B_DONE;
                    else
                        state_reg <= B_MUL0;
                B_MUL0: state_reg <= B_MUL1;
                B_MUL1: state_reg <= B_DIV;
                B_DIV:
                    if (cnt_reg == 7'd0)
                        state_reg <= B_FIN;
                B_FIN:  state_reg <= B_DONE;
                B_DONE:
                    if (!res_valid_reg || pop)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sync_disciplined_timestamp_tagger.sv =====
// throughput: one item per cycle at the input while full is low; the back takes
// one capture at a time and finishes it before it takes the next; corrected captures
// pass the bit-serial 96-step divider, uncorrected ones skip it
// reset: asynchronous active-low rst_n clears the front's time state, the queue counts,
// the result flag and config registers (sync channel reads as none); no clearing pass
`default_nettype none
module sync_disciplined_timestamp_tagger
    import sdtt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire in_item_t    in_item,
    output logic             empty,
    input  wire logic        pop,
    output out_item_t        out_item,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t cfg_reg;
    logic job_valid, job_pop;
    job_t job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_channel      <= 4'(CHANNEL_COUNT);
            cfg_reg.ideal_high_period <= '0;
            cfg_reg.ideal_low_period  <= '0;
            cfg_reg.channel_enable    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SYNC_CHANNEL: cfg_reg.sync_channel      <= cfg_data[3:0];
                REG_IDEAL_HIGH:   cfg_reg.ideal_high_period <= cfg_data;
                REG_IDEAL_LOW:    cfg_reg.ideal_low_period  <= cfg_data;
                REG_CH_ENABLE:    cfg_reg.channel_enable    <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    sdtt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    sdtt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire

// ===== rtl/core/sdtt_checker.sv =====
`default_nettype none
`include "sync_disciplined_timestamp_tagger_assert.svh"
module sdtt_checker
    import sdtt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire logic      full,
    input  wire logic      empty,
    input  wire logic      pop,
    input  wire out_item_t out_item
);

    // waiting result holds until taken
    `SDTT_ASSERT(a_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(out_item)))
    `SDTT_ASSERT(a_chan, clk, rst_n, !empty |-> (out_item.source_channel < 4'(CHANNEL_COUNT)))
    `SDTT_ASSERT(a_full, clk, rst_n, $rose(full) |-> $past(push))

endmodule

bind sync_disciplined_timestamp_tagger sdtt_checker u_sdtt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);
`default_nettype wire
